>>> hw/rtl/scl_pkg.sv
// Shared types and constants of the bilinear RGBA scaler.
package scl_pkg;

    // Fixed field widths
    localparam int COORD_W   = 8;
    localparam int SIZE_W    = 9;
    localparam int PIX_W     = 32;
    localparam int CHAN_N    = 4;
    localparam int CHAN_W    = 8;
    localparam int CFG_IDX_W = 2;

    // Result slots behind the image store (horizontal, vertical, output)
    localparam int BLEND_SLOTS = 3;

    // Command codes
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_PRODUCE = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_DST_WIDTH  = 2'd2,
        CFG_DST_HEIGHT = 2'd3
    } cfg_reg_t;

    // Ratio divider sequence
    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_X,
        DIV_Y
    } div_state_t;

    // Neighbor read sequence on the store port
    typedef enum logic [1:0] {
        RD_P11,
        RD_P12,
        RD_P21,
        RD_P22
    } rd_phase_t;

    typedef struct packed {
        logic               command;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [PIX_W-1:0]   pixel_in;
    } req_t;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_out;
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
    } rsp_t;

    typedef struct packed {
        cfg_reg_t          index;
        logic [SIZE_W-1:0] value;
    } cfg_t;

endpackage

>>> hw/rtl/scl_stream_if.sv
// Valid/ready channel carrying one payload beat.
interface scl_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/scl_ram.sv
// Generic single-port synchronous RAM with registered read data.
module scl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One access per cycle: write, or read into a registered output
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/scl_ratio_div.sv
// Restoring divider that derives the x and y scale ratios, one bit a cycle.
module scl_ratio_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [scl_pkg::SIZE_W-1:0]           src_w,
    input  logic [scl_pkg::SIZE_W-1:0]           src_h,
    input  logic [scl_pkg::SIZE_W-1:0]           dst_w,
    input  logic [scl_pkg::SIZE_W-1:0]           dst_h,
    output logic [scl_pkg::SIZE_W+FRAC_BITS-1:0] ratio_x,
    output logic [scl_pkg::SIZE_W+FRAC_BITS-1:0] ratio_y,
    output logic                                 busy
);

    localparam int RW    = scl_pkg::SIZE_W + FRAC_BITS;
    localparam int SW    = scl_pkg::SIZE_W;
    localparam int CNT_W = $clog2(RW);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(RW - 1);

    scl_pkg::div_state_t state_reg, state_next;
    logic [RW-1:0]    num_reg, num_next;
    logic [RW-1:0]    quo_reg, quo_next;
    logic [SW-1:0]    rem_reg, rem_next;
    logic [SW-1:0]    den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [RW-1:0]    ratio_x_reg, ratio_x_next;
    logic [RW-1:0]    ratio_y_reg, ratio_y_next;

    logic [SW:0]   trial;
    logic          ge;
    logic [RW-1:0] step_quo;
    logic [SW-1:0] step_rem;
    logic [RW-1:0] result;

    // Sequencer and one restoring step
    always_comb
    begin
        state_next   = state_reg;
        num_next     = num_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        den_next     = den_reg;
        cnt_next     = cnt_reg;
        ratio_x_next = ratio_x_reg;
        ratio_y_next = ratio_y_reg;

        trial    = {rem_reg, num_reg[RW-1]};
        ge       = (trial >= {1'b0, den_reg});
        step_quo = {quo_reg[RW-2:0], ge};
        step_rem = ge ? SW'(trial - {1'b0, den_reg}) : trial[SW-1:0];
        // destination size of one gives a ratio of zero
        result   = (den_reg == '0) ? '0 : step_quo;

        if (start)
        begin
            state_next = scl_pkg::DIV_X;
            num_next   = {src_w - SW'(1), {FRAC_BITS{1'b0}}};
            den_next   = dst_w - SW'(1);
            quo_next   = '0;
            rem_next   = '0;
            cnt_next   = '0;
        end
        else
        begin
            unique case (state_reg)
                scl_pkg::DIV_IDLE:
                begin
                end
                scl_pkg::DIV_X:
                begin
                    num_next = num_reg << 1;
                    quo_next = step_quo;
                    rem_next = step_rem;
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (cnt_reg == LAST)
                    begin
                        ratio_x_next = result;
                        state_next   = scl_pkg::DIV_Y;
                        num_next     = {src_h - SW'(1), {FRAC_BITS{1'b0}}};
                        den_next     = dst_h - SW'(1);
                        quo_next     = '0;
                        rem_next     = '0;
                        cnt_next     = '0;
                    end
                end
                scl_pkg::DIV_Y:
                begin
                    num_next = num_reg << 1;
                    quo_next = step_quo;
                    rem_next = step_rem;
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (cnt_reg == LAST)
                    begin
                        ratio_y_next = result;
                        state_next   = scl_pkg::DIV_IDLE;
                    end
                end
                default:
                begin
                    state_next = scl_pkg::DIV_IDLE;
                end
            endcase
        end
    end

    // State and ratios; sizes of one at reset give zero ratios
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= scl_pkg::DIV_IDLE;
            ratio_x_reg <= '0;
            ratio_y_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            ratio_x_reg <= ratio_x_next;
            ratio_y_reg <= ratio_y_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
    end

    assign ratio_x = ratio_x_reg;
    assign ratio_y = ratio_y_reg;
    assign busy    = (state_reg != scl_pkg::DIV_IDLE);

endmodule

>>> hw/rtl/scl_blend.sv
// Per-channel bilinear blend lanes: horizontal, vertical, round, output register.
module scl_blend #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic [scl_pkg::PIX_W-1:0]   p11,
    input  logic [scl_pkg::PIX_W-1:0]   p12,
    input  logic [scl_pkg::PIX_W-1:0]   p21,
    input  logic [scl_pkg::PIX_W-1:0]   p22,
    input  logic [FRAC_BITS-1:0]        fx,
    input  logic [FRAC_BITS-1:0]        fy,
    input  logic [scl_pkg::COORD_W-1:0] dx,
    input  logic [scl_pkg::COORD_W-1:0] dy,
    scl_stream_if.source                rsp,
    output logic                        retire
);

    localparam int CN    = scl_pkg::CHAN_N;
    localparam int CHW   = scl_pkg::CHAN_W;
    localparam int WGT_W = FRAC_BITS + 1;
    localparam int HW    = CHW + FRAC_BITS;
    localparam int VW    = CHW + 2 * FRAC_BITS;
    localparam logic [WGT_W-1:0] ONE  = WGT_W'(1) << FRAC_BITS;
    localparam logic [VW-1:0]    HALF = VW'(1) << (2 * FRAC_BITS - 1);

    logic                        h_valid_reg, v_valid_reg, o_valid_reg;
    logic [HW-1:0]               h_top_reg [CN];
    logic [HW-1:0]               h_bot_reg [CN];
    logic [FRAC_BITS-1:0]        h_fy_reg;
    logic [scl_pkg::COORD_W-1:0] h_dx_reg, h_dy_reg;
    logic [VW-1:0]               v_sum_reg [CN];
    logic [scl_pkg::COORD_W-1:0] v_dx_reg, v_dy_reg;
    logic [scl_pkg::PIX_W-1:0]   o_pix_reg;
    logic [scl_pkg::COORD_W-1:0] o_dx_reg, o_dy_reg;

    logic [HW-1:0]             h_top_next [CN];
    logic [HW-1:0]             h_bot_next [CN];
    logic [VW-1:0]             v_sum_next [CN];
    logic [VW-1:0]             rnd [CN];
    logic [scl_pkg::PIX_W-1:0] o_pix_next;
    logic [WGT_W-1:0]          wx0, wy0;
    logic                      o_free, v_adv, h_adv;

    // Stage moves when the next one is empty or moving
    assign o_free = !o_valid_reg || rsp.ready;
    assign v_adv  = v_valid_reg && o_free;
    assign h_adv  = h_valid_reg && (!v_valid_reg || v_adv);

    // Lane arithmetic
    always_comb
    begin
        wx0 = ONE - WGT_W'(fx);
        wy0 = ONE - WGT_W'(h_fy_reg);
        for (int c = 0; c < CN; c++)
        begin
            h_top_next[c] = HW'(p11[c*CHW +: CHW]) * HW'(wx0)
                          + HW'(p12[c*CHW +: CHW]) * HW'(fx);
            h_bot_next[c] = HW'(p21[c*CHW +: CHW]) * HW'(wx0)
                          + HW'(p22[c*CHW +: CHW]) * HW'(fx);
            v_sum_next[c] = VW'(h_top_reg[c]) * VW'(wy0)
                          + VW'(h_bot_reg[c]) * VW'(h_fy_reg);
            // round half up; the sum never exceeds 255.5 after scaling
            rnd[c] = v_sum_reg[c] + HALF;
            o_pix_next[c*CHW +: CHW] = rnd[c][VW-1 -: CHW];
        end
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_valid_reg <= 1'b0;
            v_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                h_valid_reg <= 1'b1;
            end
            else if (h_adv)
            begin
                h_valid_reg <= 1'b0;
            end

            if (h_adv)
            begin
                v_valid_reg <= 1'b1;
            end
            else if (v_adv)
            begin
                v_valid_reg <= 1'b0;
            end

            if (v_adv)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            for (int c = 0; c < CN; c++)
            begin
                h_top_reg[c] <= h_top_next[c];
                h_bot_reg[c] <= h_bot_next[c];
            end
            h_fy_reg <= fy;
            h_dx_reg <= dx;
            h_dy_reg <= dy;
        end
        if (h_adv)
        begin
            for (int c = 0; c < CN; c++)
            begin
                v_sum_reg[c] <= v_sum_next[c];
            end
            v_dx_reg <= h_dx_reg;
            v_dy_reg <= h_dy_reg;
        end
        if (v_adv)
        begin
            o_pix_reg <= o_pix_next;
            o_dx_reg  <= v_dx_reg;
            o_dy_reg  <= v_dy_reg;
        end
    end

    assign rsp.valid          = o_valid_reg;
    assign rsp.data.pixel_out = o_pix_reg;
    assign rsp.data.out_x     = o_dx_reg;
    assign rsp.data.out_y     = o_dy_reg;
    assign retire             = o_valid_reg && rsp.ready;

endmodule

>>> hw/rtl/bilinear_rgba_scaler_core.sv
// Top level of the bilinear RGBA scaler: image store, address path, ratio unit, blend.
//
//  Channel | Dir  | Payload                                  | Beat
//  --------+------+------------------------------------------+-------------------------
//  req     | in   | command, pos_x, pos_y, pixel_in          | load or produce request
//  rsp     | out  | pixel_out, out_x, out_y                  | one per produce request
//  cfg     | in   | index (src_w, src_h, dst_w, dst_h), value| register write
//
//  A load beat takes one write of the store port; a produce beat takes four reads (one per
//  neighbor on the single-port store), and no new beat enters the store stage until the last
//  read of a produce is issued. Reset sets all sizes to 1 and zero ratios; the store is not
//  cleared. After a cfg write, req is held off while the ratio divider runs. Up to three
//  results wait behind a stalled rsp before reads pause.
module bilinear_rgba_scaler_core #(
    parameter int MAX_DIM   = 256,
    parameter int FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    scl_stream_if.sink   req,
    scl_stream_if.source rsp,
    scl_stream_if.sink   cfg
);

    localparam int SW    = scl_pkg::SIZE_W;
    localparam int CRW   = scl_pkg::COORD_W;
    localparam int CW    = $clog2(MAX_DIM);
    localparam int AW    = 2 * CW;
    localparam int DEPTH = 1 << AW;
    localparam int RW    = SW + FRAC_BITS;
    localparam int PW    = CRW + RW;
    localparam int XW    = PW - FRAC_BITS;
    localparam logic [1:0] CREDIT_MAX = 2'(scl_pkg::BLEND_SLOTS);

    // Configuration
    logic [SW-1:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    logic [SW-1:0] cfg_eff;
    logic          cfg_wr_reg;
    logic [RW-1:0] ratio_x, ratio_y;
    logic          div_busy;

    // Request stage
    logic                       s1_valid_reg, s1_cmd_reg;
    logic [CRW-1:0]             s1_x_reg, s1_y_reg;
    logic [scl_pkg::PIX_W-1:0]  s1_pix_reg;
    // Scale stage
    logic                       s2_valid_reg, s2_cmd_reg;
    logic [CRW-1:0]             s2_x_reg, s2_y_reg;
    logic [scl_pkg::PIX_W-1:0]  s2_pix_reg;
    logic [PW-1:0]              s2_sx_reg, s2_sy_reg;
    // Store access stage
    logic                       s3_valid_reg, s3_cmd_reg;
    logic [CRW-1:0]             s3_dx_reg, s3_dy_reg;
    logic [scl_pkg::PIX_W-1:0]  s3_pix_reg;
    logic [CW-1:0]              s3_x1_reg, s3_y1_reg, s3_x2_reg, s3_y2_reg;
    logic [FRAC_BITS-1:0]       s3_fx_reg, s3_fy_reg;
    scl_pkg::rd_phase_t         s3_phase_reg, s3_phase_next;
    // Read return
    logic                       rd_valid_reg;
    scl_pkg::rd_phase_t         rd_phase_reg;
    logic [scl_pkg::PIX_W-1:0]  coll_p11_reg, coll_p12_reg, coll_p21_reg;
    logic [CRW-1:0]             m_dx_reg, m_dy_reg;
    logic [FRAC_BITS-1:0]       m_fx_reg, m_fy_reg;
    logic [1:0]                 credit_reg, credit_next;

    logic                       req_fire, s1_adv, s2_adv, s3_done;
    logic [SW-1:0]              in_size_x, in_size_y;
    logic [CRW-1:0]             in_x_cl, in_y_cl;
    logic [XW-1:0]              x1_raw, y1_raw;
    logic [SW-1:0]              sw_m1, sh_m1, x1_cl, y1_cl, x2_cl, y2_cl;
    logic [SW:0]                x1_inc, y1_inc;
    logic [CW-1:0]              x1_next, y1_next, x2_next, y2_next;
    logic                       ram_en, ram_we, credit_inc, push, retire;
    logic [AW-1:0]              ram_addr;
    logic [scl_pkg::PIX_W-1:0]  ram_rdata;

    // Size registers hold the effective size (0 acts as 1, clamp at MAX_DIM)
    always_comb
    begin
        cfg_eff = cfg.data.value;
        if (cfg.data.value == '0)
        begin
            cfg_eff = SW'(1);
        end
        else if (32'(cfg.data.value) > MAX_DIM)
        begin
            cfg_eff = SW'(MAX_DIM);
        end
    end

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg  <= SW'(1);
            src_h_reg  <= SW'(1);
            dst_w_reg  <= SW'(1);
            dst_h_reg  <= SW'(1);
            cfg_wr_reg <= 1'b0;
        end
        else
        begin
            cfg_wr_reg <= cfg.valid;
            if (cfg.valid)
            begin
                unique case (cfg.data.index)
                    scl_pkg::CFG_SRC_WIDTH:  src_w_reg <= cfg_eff;
                    scl_pkg::CFG_SRC_HEIGHT: src_h_reg <= cfg_eff;
                    scl_pkg::CFG_DST_WIDTH:  dst_w_reg <= cfg_eff;
                    scl_pkg::CFG_DST_HEIGHT: dst_h_reg <= cfg_eff;
                endcase
            end
        end
    end

    // Ratio unit, restarted by every register write
    scl_ratio_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ratio_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cfg_wr_reg),
        .src_w   (src_w_reg),
        .src_h   (src_h_reg),
        .dst_w   (dst_w_reg),
        .dst_h   (dst_h_reg),
        .ratio_x (ratio_x),
        .ratio_y (ratio_y),
        .busy    (div_busy)
    );

    // Pipeline handshakes
    assign s2_adv    = s2_valid_reg && (!s3_valid_reg || s3_done);
    assign s1_adv    = s1_valid_reg && (!s2_valid_reg || s2_adv);
    assign req.ready = !div_busy && !cfg_wr_reg && (!s1_valid_reg || s1_adv);
    assign req_fire  = req.valid && req.ready;

    // Coordinate clamp on entry: source size for loads, destination size for produces
    always_comb
    begin
        in_size_x = (req.data.command == scl_pkg::CMD_LOAD) ? src_w_reg : dst_w_reg;
        in_size_y = (req.data.command == scl_pkg::CMD_LOAD) ? src_h_reg : dst_h_reg;
        in_x_cl   = (SW'(req.data.pos_x) > in_size_x - SW'(1)) ?
                    CRW'(in_size_x - SW'(1)) : req.data.pos_x;
        in_y_cl   = (SW'(req.data.pos_y) > in_size_y - SW'(1)) ?
                    CRW'(in_size_y - SW'(1)) : req.data.pos_y;
    end

    // Neighbor coordinates from the scaled position
    always_comb
    begin
        sw_m1  = src_w_reg - SW'(1);
        sh_m1  = src_h_reg - SW'(1);
        x1_raw = s2_sx_reg[PW-1:FRAC_BITS];
        y1_raw = s2_sy_reg[PW-1:FRAC_BITS];
        x1_cl  = (x1_raw > XW'(sw_m1)) ? sw_m1 : SW'(x1_raw);
        y1_cl  = (y1_raw > XW'(sh_m1)) ? sh_m1 : SW'(y1_raw);
        x1_inc = {1'b0, x1_cl} + (SW+1)'(1);
        y1_inc = {1'b0, y1_cl} + (SW+1)'(1);
        x2_cl  = (x1_inc < {1'b0, src_w_reg}) ? SW'(x1_inc) : sw_m1;
        y2_cl  = (y1_inc < {1'b0, src_h_reg}) ? SW'(y1_inc) : sh_m1;
        if (s2_cmd_reg == scl_pkg::CMD_LOAD)
        begin
            x1_next = CW'(s2_x_reg);
            y1_next = CW'(s2_y_reg);
        end
        else
        begin
            x1_next = CW'(x1_cl);
            y1_next = CW'(y1_cl);
        end
        x2_next = CW'(x2_cl);
        y2_next = CW'(y2_cl);
    end

    // Store port sequencer: one write per load, four reads per produce
    always_comb
    begin
        ram_en        = 1'b0;
        ram_we        = 1'b0;
        ram_addr      = {s3_y1_reg, s3_x1_reg};
        s3_done       = 1'b0;
        credit_inc    = 1'b0;
        s3_phase_next = s3_phase_reg;
        if (s3_valid_reg)
        begin
            if (s3_cmd_reg == scl_pkg::CMD_LOAD)
            begin
                ram_en  = 1'b1;
                ram_we  = 1'b1;
                s3_done = 1'b1;
            end
            else if ((s3_phase_reg != scl_pkg::RD_P11) || (credit_reg < CREDIT_MAX))
            begin
                ram_en = 1'b1;
                unique case (s3_phase_reg)
                    scl_pkg::RD_P11:
                    begin
                        credit_inc    = 1'b1;
                        s3_phase_next = scl_pkg::RD_P12;
                    end
                    scl_pkg::RD_P12:
                    begin
                        ram_addr      = {s3_y1_reg, s3_x2_reg};
                        s3_phase_next = scl_pkg::RD_P21;
                    end
                    scl_pkg::RD_P21:
                    begin
                        ram_addr      = {s3_y2_reg, s3_x1_reg};
                        s3_phase_next = scl_pkg::RD_P22;
                    end
                    scl_pkg::RD_P22:
                    begin
                        ram_addr      = {s3_y2_reg, s3_x2_reg};
                        s3_phase_next = scl_pkg::RD_P11;
                        s3_done       = 1'b1;
                    end
                endcase
            end
        end
    end

    // Results in flight from first read to output beat
    always_comb
    begin
        credit_next = credit_reg;
        if (credit_inc && !retire)
        begin
            credit_next = credit_reg + 2'd1;
        end
        else if (!credit_inc && retire)
        begin
            credit_next = credit_reg - 2'd1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s3_phase_reg <= scl_pkg::RD_P11;
            rd_valid_reg <= 1'b0;
            credit_reg   <= '0;
        end
        else
        begin
            if (req_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (s2_adv)
            begin
                s3_valid_reg <= 1'b1;
            end
            else if (s3_done)
            begin
                s3_valid_reg <= 1'b0;
            end

            s3_phase_reg <= s3_phase_next;
            rd_valid_reg <= ram_en && !ram_we;
            credit_reg   <= credit_next;
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_cmd_reg <= req.data.command;
            s1_x_reg   <= in_x_cl;
            s1_y_reg   <= in_y_cl;
            s1_pix_reg <= req.data.pixel_in;
        end
        if (s1_adv)
        begin
            s2_cmd_reg <= s1_cmd_reg;
            s2_x_reg   <= s1_x_reg;
            s2_y_reg   <= s1_y_reg;
            s2_pix_reg <= s1_pix_reg;
            s2_sx_reg  <= PW'(s1_x_reg) * PW'(ratio_x);
            s2_sy_reg  <= PW'(s1_y_reg) * PW'(ratio_y);
        end
        if (s2_adv)
        begin
            s3_cmd_reg <= s2_cmd_reg;
            s3_dx_reg  <= s2_x_reg;
            s3_dy_reg  <= s2_y_reg;
            s3_pix_reg <= s2_pix_reg;
            s3_x1_reg  <= x1_next;
            s3_y1_reg  <= y1_next;
            s3_x2_reg  <= x2_next;
            s3_y2_reg  <= y2_next;
            s3_fx_reg  <= s2_sx_reg[FRAC_BITS-1:0];
            s3_fy_reg  <= s2_sy_reg[FRAC_BITS-1:0];
        end
        rd_phase_reg <= s3_phase_reg;
        // keep weights and position with the last read of a produce
        if (ram_en && !ram_we && (s3_phase_reg == scl_pkg::RD_P22))
        begin
            m_dx_reg <= s3_dx_reg;
            m_dy_reg <= s3_dy_reg;
            m_fx_reg <= s3_fx_reg;
            m_fy_reg <= s3_fy_reg;
        end
        // collect the first three neighbors as they return
        if (rd_valid_reg)
        begin
            case (rd_phase_reg)
                scl_pkg::RD_P11: coll_p11_reg <= ram_rdata;
                scl_pkg::RD_P12: coll_p12_reg <= ram_rdata;
                scl_pkg::RD_P21: coll_p21_reg <= ram_rdata;
                default:
                begin
                end
            endcase
        end
    end

    // Source image store
    scl_ram #(
        .WIDTH (scl_pkg::PIX_W),
        .DEPTH (DEPTH)
    ) u_image_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s3_pix_reg),
        .rdata (ram_rdata)
    );

    assign push = rd_valid_reg && (rd_phase_reg == scl_pkg::RD_P22);

    // Blend lanes and output register
    scl_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .p11    (coll_p11_reg),
        .p12    (coll_p12_reg),
        .p21    (coll_p21_reg),
        .p22    (ram_rdata),
        .fx     (m_fx_reg),
        .fy     (m_fy_reg),
        .dx     (m_dx_reg),
        .dy     (m_dy_reg),
        .rsp    (rsp),
        .retire (retire)
    );

endmodule
